// ===== sv/cca_pkg.sv =====
// Shared types, widths, codes and default sizes of the cluster centroid accumulator.
package cca_pkg;

   // Default sizes of the stores.
   localparam int MAX_CLUSTERS_DEF = 256;
   localparam int MAX_DIM_DEF      = 128;
   localparam int MAX_VECTORS_DEF  = 65536;

   // Field widths of the request and response items.
   localparam int MODE_W    = 2;
   localparam int CLUSTER_W = 9;
   localparam int DIM_IDX_W = 7;
   localparam int SAMPLE_W  = 16;
   localparam int MEAN_W    = 16;

   // Running sums are signed 33-bit values that saturate.
   localparam int SUM_W = 33;

   // Configuration port.
   localparam int NUM_CLUSTERS_W = 9;
   localparam int VECTOR_DIM_W   = 8;
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CLUSTERS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VECTOR_DIM   = 1'd1;
   localparam logic [NUM_CLUSTERS_W-1:0] NUM_CLUSTERS_RST = 9'd256;
   localparam logic [VECTOR_DIM_W-1:0]   VECTOR_DIM_RST   = 8'd128;

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_ACCUMULATE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ       = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR      = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED     = 2'd3;

   // Status of the shared divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== sv/cca_req_if.sv =====
// Request channel of the cluster centroid accumulator.
interface cca_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [cca_pkg::MODE_W-1:0]              mode;
   logic signed [cca_pkg::CLUSTER_W-1:0]    cluster;
   logic [cca_pkg::DIM_IDX_W-1:0]           dim_index;
   logic signed [cca_pkg::SAMPLE_W-1:0]     sample;
   logic                                    vector_end;

   modport source (
      output valid, mode, cluster, dim_index, sample, vector_end,
      input  ready
   );

   modport sink (
      input  valid, mode, cluster, dim_index, sample, vector_end,
      output ready
   );
endinterface

// ===== sv/cca_rsp_if.sv =====
// Response channel of the cluster centroid accumulator.
interface cca_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [cca_pkg::MEAN_W-1:0]    mean;
   logic                                 empty_res;

   modport source (
      output valid, mean, empty_res,
      input  ready
   );

   modport sink (
      input  valid, mean, empty_res,
      output ready
   );
endinterface

// ===== sv/cca_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module cca_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/cca_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
module cca_divider #(
   parameter int DIVIDEND_W = 33,
   parameter int DIVISOR_W  = 17
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DIVIDEND_W-1:0]   dividend,
   input  logic [DIVISOR_W-1:0]    divisor,
   output logic [DIVIDEND_W-1:0]   quotient,
   output cca_pkg::div_status_type status
);

   localparam int IT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [IT_W-1:0]       iter_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // One trial subtraction: bring down the next dividend bit and subtract if it fits.
   always_comb begin
      trial  = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      fits   = (trial >= {1'b0, dvs_ff});
      rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
   end

   // Iteration control.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= busy_ff && (iter_ff == IT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            iter_ff <= IT_W'(DIVIDEND_W);
         end else if (busy_ff) begin
            busy_ff <= (iter_ff != IT_W'(1));
            iter_ff <= iter_ff - IT_W'(1);
         end
      end
   end

   // Dividend shifts out while the quotient shifts in behind it.
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== sv/cluster_centroid_accumulator_unit.sv =====
// Top level of the cluster centroid accumulator: sequencer, stores and response register.
// Accumulate requests are accepted, then the sum and count take a read-modify-write.
// Read requests go through memory read, 33 steps of the shared divider, sign and
// saturation, then the response register; empty or invalid reads skip the divider.
// Clear requests and reset start a clearing pass over MAX_CLUSTERS' * MAX_DIM' entries
// (both rounded up to a power of two; 32768 by default), with no request accepted.
// Configuration writes are taken in every cycle; reset sets the registers to 256 and 128.
module cluster_centroid_accumulator_unit #(
   parameter int MAX_CLUSTERS = cca_pkg::MAX_CLUSTERS_DEF,
   parameter int MAX_DIM      = cca_pkg::MAX_DIM_DEF,
   parameter int MAX_VECTORS  = cca_pkg::MAX_VECTORS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   cca_req_if.sink                          req_chan,
   cca_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [cca_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cca_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CL_W      = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int DIM_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int SUM_AW    = CL_W + DIM_W;
   localparam int SUM_DEPTH = 1 << SUM_AW;
   localparam int CNT_DEPTH = 1 << CL_W;
   localparam int CNT_W     = $clog2(MAX_VECTORS + 1);
   localparam int SUM_W     = cca_pkg::SUM_W;
   localparam int SAMPLE_W  = cca_pkg::SAMPLE_W;
   localparam int MEAN_W    = cca_pkg::MEAN_W;
   localparam int CLUSTER_W = cca_pkg::CLUSTER_W;
   localparam int DIM_IDX_W = cca_pkg::DIM_IDX_W;

   // Sequencer states.
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_ACC   = 3'd2;
   localparam logic [2:0] ST_RD    = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   localparam logic [SUM_W-1:0] SUM_POS_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] SUM_NEG_MAX = {1'b1, {(SUM_W-1){1'b0}}};

   logic [2:0]                         state_ff, state_in;
   logic [SUM_AW-1:0]                  clr_addr_ff, clr_addr_in;
   logic [cca_pkg::NUM_CLUSTERS_W-1:0] num_clusters_ff;
   logic [cca_pkg::VECTOR_DIM_W-1:0]   vector_dim_ff;

   logic [CL_W-1:0]                    c_idx_ff, c_idx_in;
   logic [DIM_W-1:0]                   d_idx_ff, d_idx_in;
   logic                               dval_ff, dval_in;
   logic signed [SAMPLE_W-1:0]         sample_ff, sample_in;
   logic                               vend_ff, vend_in;
   logic                               neg_ff, neg_in;
   logic [MEAN_W-1:0]                  res_mean_ff, res_mean_in;
   logic                               res_empty_ff, res_empty_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [MEAN_W-1:0]                  rsp_mean_ff;
   logic                               rsp_empty_ff;
   logic                               rsp_load;

   logic                               req_fire;
   logic [31:0]                        cl_ext;
   logic [31:0]                        d_ext;
   logic                               cval;
   logic                               dval;

   logic                               sum_we;
   logic [SUM_AW-1:0]                  sum_waddr;
   logic [SUM_W-1:0]                   sum_wdata;
   logic [SUM_AW-1:0]                  sum_raddr;
   logic [SUM_W-1:0]                   sum_rdata;
   logic                               cnt_we;
   logic [CL_W-1:0]                    cnt_waddr;
   logic [CNT_W-1:0]                   cnt_wdata;
   logic [CL_W-1:0]                    cnt_raddr;
   logic [CNT_W-1:0]                   cnt_rdata;

   logic [SUM_W:0]                     sum_add;
   logic [SUM_W-1:0]                   sum_sat;
   logic [SUM_W-1:0]                   sum_mag;
   logic                               div_start;
   logic [SUM_W-1:0]                   div_quotient;
   cca_pkg::div_status_type            div_stat;

   // Request decode: cluster and dimension checks against registers and store sizes.
   always_comb begin
      req_fire = req_chan.valid && req_chan.ready;
      cl_ext   = {{(32-CLUSTER_W+1){1'b0}}, req_chan.cluster[CLUSTER_W-2:0]};
      d_ext    = {{(32-DIM_IDX_W){1'b0}}, req_chan.dim_index};
      cval     = !req_chan.cluster[CLUSTER_W-1]
                 && (cl_ext < 32'(num_clusters_ff))
                 && (cl_ext < 32'(MAX_CLUSTERS));
      dval     = (d_ext < 32'(vector_dim_ff)) && (d_ext < 32'(MAX_DIM));
      cnt_raddr = cl_ext[CL_W-1:0];
      sum_raddr = {cl_ext[CL_W-1:0], d_ext[DIM_W-1:0]};
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   // Saturating add of the sample to the running sum.
   always_comb begin
      sum_add = {sum_rdata[SUM_W-1], sum_rdata}
                + {{(SUM_W+1-SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff};
      if (sum_add[SUM_W] != sum_add[SUM_W-1]) begin
         sum_sat = sum_add[SUM_W] ? SUM_NEG_MAX : SUM_POS_MAX;
      end else begin
         sum_sat = sum_add[SUM_W-1:0];
      end
      sum_mag = sum_rdata[SUM_W-1] ? (~sum_rdata + SUM_W'(1)) : sum_rdata;
   end

   // Sequencer: next state, store writes and divider start.
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      c_idx_in     = c_idx_ff;
      d_idx_in     = d_idx_ff;
      dval_in      = dval_ff;
      sample_in    = sample_ff;
      vend_in      = vend_ff;
      neg_in       = neg_ff;
      res_mean_in  = res_mean_ff;
      res_empty_in = res_empty_ff;
      sum_we       = 1'b0;
      sum_waddr    = {c_idx_ff, d_idx_ff};
      sum_wdata    = sum_sat;
      cnt_we       = 1'b0;
      cnt_waddr    = c_idx_ff;
      cnt_wdata    = cnt_rdata + CNT_W'(1);
      div_start    = 1'b0;
      rsp_load     = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            sum_we      = 1'b1;
            sum_waddr   = clr_addr_ff;
            sum_wdata   = '0;
            cnt_we      = 1'b1;
            cnt_waddr   = clr_addr_ff[SUM_AW-1:DIM_W];
            cnt_wdata   = '0;
            clr_addr_in = clr_addr_ff + SUM_AW'(1);
            if (clr_addr_ff == {SUM_AW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            c_idx_in  = cl_ext[CL_W-1:0];
            d_idx_in  = d_ext[DIM_W-1:0];
            dval_in   = dval;
            sample_in = req_chan.sample;
            vend_in   = req_chan.vector_end;
            if (req_fire) begin
               unique case (req_chan.mode)
                  cca_pkg::MODE_ACCUMULATE: begin
                     if (cval) begin
                        state_in = ST_ACC;
                     end
                  end
                  cca_pkg::MODE_READ: begin
                     if (cval && dval) begin
                        state_in = ST_RD;
                     end else begin
                        res_mean_in  = '0;
                        res_empty_in = 1'b1;
                        state_in     = ST_OUT;
                     end
                  end
                  cca_pkg::MODE_CLEAR: begin
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end
                  cca_pkg::MODE_UNUSED: begin
                     state_in = ST_IDLE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ACC: begin
            // A cluster whose count has reached the limit takes no more adds.
            if (cnt_rdata < CNT_W'(MAX_VECTORS)) begin
               sum_we = dval_ff;
               cnt_we = vend_ff;
            end
            state_in = ST_IDLE;
         end
         ST_RD: begin
            if (cnt_rdata == '0) begin
               res_mean_in  = '0;
               res_empty_in = 1'b1;
               state_in     = ST_OUT;
            end else begin
               div_start = 1'b1;
               neg_in    = sum_rdata[SUM_W-1];
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            // Restore the sign and saturate to the Q8.8 range.
            if (div_stat.done) begin
               res_empty_in = 1'b0;
               if (neg_ff) begin
                  if (div_quotient > SUM_W'(32768)) begin
                     res_mean_in = {1'b1, {(MEAN_W-1){1'b0}}};
                  end else begin
                     res_mean_in = ~div_quotient[MEAN_W-1:0] + MEAN_W'(1);
                  end
               end else begin
                  if (div_quotient > SUM_W'(32767)) begin
                     res_mean_in = {1'b0, {(MEAN_W-1){1'b1}}};
                  end else begin
                     res_mean_in = div_quotient[MEAN_W-1:0];
                  end
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_clusters_ff <= cca_pkg::NUM_CLUSTERS_RST;
         vector_dim_ff   <= cca_pkg::VECTOR_DIM_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            cca_pkg::CSR_NUM_CLUSTERS: num_clusters_ff <= csr_wdata;
            cca_pkg::CSR_VECTOR_DIM:   vector_dim_ff   <= csr_wdata[cca_pkg::VECTOR_DIM_W-1:0];
            default:                   num_clusters_ff <= num_clusters_ff;
         endcase
      end
   end

   // Request fields held while the request is worked on, and the response payload.
   always_ff @(posedge clock) begin
      c_idx_ff     <= c_idx_in;
      d_idx_ff     <= d_idx_in;
      dval_ff      <= dval_in;
      sample_ff    <= sample_in;
      vend_ff      <= vend_in;
      neg_ff       <= neg_in;
      res_mean_ff  <= res_mean_in;
      res_empty_ff <= res_empty_in;
      if (rsp_load) begin
         rsp_mean_ff  <= res_mean_ff;
         rsp_empty_ff <= res_empty_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.mean      = rsp_mean_ff;
   assign rsp_chan.empty_res = rsp_empty_ff;

   // Running sums, one per cluster and dimension.
   cca_ram #(
      .WIDTH (SUM_W),
      .DEPTH (SUM_DEPTH)
   ) u_sum_ram (
      .clock (clock),
      .we    (sum_we),
      .waddr (sum_waddr),
      .wdata (sum_wdata),
      .raddr (sum_raddr),
      .rdata (sum_rdata)
   );

   // Member counts, one per cluster.
   cca_ram #(
      .WIDTH (CNT_W),
      .DEPTH (CNT_DEPTH)
   ) u_cnt_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .raddr (cnt_raddr),
      .rdata (cnt_rdata)
   );

   // Shared divider for sum over count.
   cca_divider #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (cnt_rdata),
      .quotient (div_quotient),
      .status   (div_stat)
   );

`ifndef SYNTHESIS
   // The cycle after reset the block is in its clearing pass.
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (state_ff == ST_CLEAR))
      else $error("block not clearing after reset");

   // A new response only follows the output state of the sequencer.
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(state_ff) == ST_OUT))
      else $error("response raised outside the output state");

   // An empty response carries a zero mean.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_mean_ff == '0))
      else $error("empty response with nonzero mean");

   // The divider finishes only while the sequencer waits for it.
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   // A count update never goes past the member limit.
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      (cnt_we && (state_ff == ST_ACC)) |-> (cnt_wdata <= CNT_W'(MAX_VECTORS)))
      else $error("member count above limit");
`endif

endmodule

// ===== dv/centroid_mean_checker.sv =====
// Checker that predicts centroid means from observed requests and compares the responses.
`timescale 1ns / 1ps

module centroid_mean_checker (
   input  logic                            clock,
   input  logic                            reset,
   cca_req_if                              req_mon,
   cca_rsp_if                              rsp_mon,
   input  logic                            csr_we,
   input  logic [cca_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cca_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              mismatch_total,
   output int                              means_pending
);
   import cca_pkg::*;

   localparam int     STORE_DEPTH = MAX_CLUSTERS_DEF * MAX_DIM_DEF;
   localparam longint SUM_TOP     = (64'sd1 <<< (SUM_W - 1)) - 64'sd1;
   localparam longint SUM_BOTTOM  = -(64'sd1 <<< (SUM_W - 1));
   localparam longint MEAN_TOP    = (64'sd1 <<< (MEAN_W - 1)) - 64'sd1;
   localparam longint MEAN_BOTTOM = -(64'sd1 <<< (MEAN_W - 1));

   typedef struct {
      logic signed [MEAN_W-1:0] mean;
      logic                     empty_res;
   } centre_mean_t;

   // Shadow copy of the sums, member counts and registers.
   longint                    element_total [STORE_DEPTH];
   int                        member_total  [MAX_CLUSTERS_DEF];
   logic [NUM_CLUSTERS_W-1:0] clusters_in_use;
   logic [VECTOR_DIM_W-1:0]   dims_in_use;
   centre_mean_t              expected_means [$];
   int                        mismatch_count = 0;

   assign mismatch_total = mismatch_count;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatch_count < 100) begin
         $display("%0t ns: centroid mismatch, %s: got %0d, expected %0d",
                  $time, what, got, want);
      end
      mismatch_count++;
   endtask

   function automatic void wipe_store();
      foreach (element_total[i]) element_total[i] = 0;
      foreach (member_total[i]) member_total[i] = 0;
   endfunction

   // Update the shadow store for one accepted request, and queue the mean a read yields.
   function automatic void apply_request(input logic [MODE_W-1:0] mode,
                                         input logic signed [CLUSTER_W-1:0] cluster,
                                         input logic [DIM_IDX_W-1:0] dim_index,
                                         input logic signed [SAMPLE_W-1:0] sample,
                                         input logic vector_end);
      int           eff_clusters;
      int           eff_dims;
      int           cl_i;
      int           dim_i;
      int           slot;
      bit           cluster_ok;
      bit           dim_ok;
      longint       next_sum;
      longint       quotient;
      centre_mean_t want;

      eff_clusters = (clusters_in_use > MAX_CLUSTERS_DEF) ? MAX_CLUSTERS_DEF
                                                          : int'(clusters_in_use);
      eff_dims     = (dims_in_use > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(dims_in_use);
      cl_i         = cluster;
      dim_i        = int'(dim_index);
      cluster_ok   = (cl_i >= 0) && (cl_i < eff_clusters);
      dim_ok       = dim_i < eff_dims;
      slot         = cl_i * MAX_DIM_DEF + dim_i;

      case (mode)
         MODE_ACCUMULATE: begin
            // A full cluster drops both the sample and the member.
            if (cluster_ok && member_total[cl_i] < MAX_VECTORS_DEF) begin
               if (dim_ok) begin
                  next_sum = element_total[slot] + longint'(sample);
                  if (next_sum > SUM_TOP) next_sum = SUM_TOP;
                  if (next_sum < SUM_BOTTOM) next_sum = SUM_BOTTOM;
                  element_total[slot] = next_sum;
               end
               if (vector_end) member_total[cl_i]++;
            end
         end
         MODE_READ: begin
            want.mean      = '0;
            want.empty_res = 1'b1;
            if (cluster_ok && dim_ok && member_total[cl_i] > 0) begin
               // Integer division truncates toward zero, as the mean must.
               quotient = element_total[slot] / longint'(member_total[cl_i]);
               if (quotient > MEAN_TOP) quotient = MEAN_TOP;
               if (quotient < MEAN_BOTTOM) quotient = MEAN_BOTTOM;
               want.mean      = quotient[MEAN_W-1:0];
               want.empty_res = 1'b0;
            end
            expected_means = {expected_means, want};
         end
         MODE_CLEAR: wipe_store();
         default: ;
      endcase
   endfunction

   // Compare one accepted response against the oldest expected mean.
   task automatic check_mean(input logic signed [MEAN_W-1:0] mean,
                             input logic empty_res);
      centre_mean_t want;

      if (expected_means.size() == 0) begin
         report_mismatch("response with no read outstanding", mean, 0);
         return;
      end
      want = expected_means.pop_front();
      if (mean !== want.mean) report_mismatch("mean", mean, want.mean);
      if (empty_res !== want.empty_res) report_mismatch("empty_res", empty_res, want.empty_res);
   endtask

   // Sample both channels and the register port at every rising edge.
   always @(posedge clock) begin
      if (reset) begin
         wipe_store();
         clusters_in_use = NUM_CLUSTERS_RST;
         dims_in_use     = VECTOR_DIM_RST;
         expected_means.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_mean(rsp_mon.mean, rsp_mon.empty_res);
         if (req_mon.valid && req_mon.ready) begin
            apply_request(req_mon.mode, req_mon.cluster, req_mon.dim_index,
                          req_mon.sample, req_mon.vector_end);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_NUM_CLUSTERS: clusters_in_use = csr_wdata[NUM_CLUSTERS_W-1:0];
               CSR_VECTOR_DIM:   dims_in_use     = csr_wdata[VECTOR_DIM_W-1:0];
               default: ;
            endcase
         end
      end
      means_pending <= expected_means.size();
   end

endmodule

// ===== dv/tb_top.sv =====
// Top of the centroid accumulator testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
   import cca_pkg::*;

   localparam int SAT_CLUSTER = 200;

   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_HICCUP} rx_style_e;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    mismatch_total;
   int                    means_pending;
   int                    burst_left = 0;
   bit                    bulk_mode = 1'b0;
   rx_style_e             rx_style = RX_OPEN;
   int                    rx_hold = 0;

   cca_req_if req_chan ();
   cca_rsp_if rsp_chan ();

   cluster_centroid_accumulator_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   centroid_mean_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_total (mismatch_total),
      .means_pending  (means_pending)
   );

   always #1 clock = ~clock;

   // The response side switches between stall styles at random.
   always @(posedge clock) begin
      if (rx_hold == 0) begin
         rx_style = rx_style_e'($urandom_range(0, 3));
         rx_hold  = $urandom_range(50, 400);
      end else begin
         rx_hold = rx_hold - 1;
      end
      case (rx_style)
         RX_OPEN:   rsp_chan.ready <= 1'b1;
         RX_COIN:   rsp_chan.ready <= ($urandom_range(0, 1) == 1);
         RX_SPARSE: rsp_chan.ready <= (rx_hold % 8 == 0);
         default:   rsp_chan.ready <= ($urandom_range(0, 9) != 0);
      endcase
   end

   // Drive one request and hold it until it is accepted; requests come in bursts.
   task automatic send_request(input logic [MODE_W-1:0] mode, input int cl, input int dim,
                               input int sample, input bit vector_end);
      int gap;

      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (bulk_mode || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid      <= 1'b1;
      req_chan.mode       <= mode;
      req_chan.cluster    <= cl[CLUSTER_W-1:0];
      req_chan.dim_index  <= dim[DIM_IDX_W-1:0];
      req_chan.sample     <= sample[SAMPLE_W-1:0];
      req_chan.vector_end <= vector_end;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Hold off new requests until every outstanding mean has been returned.
   task automatic drain_means();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (means_pending != 0);
   endtask

   // A read behind all earlier work proves the block idle, clears included.
   task automatic write_regs(input int clusters, input int dims);
      send_request(MODE_READ, 0, 0, 0, 1'b0);
      drain_means();
      repeat (40) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_NUM_CLUSTERS;
      csr_wdata <= CSR_DATA_W'(clusters);
      @(posedge clock);
      csr_index <= CSR_VECTOR_DIM;
      csr_wdata <= CSR_DATA_W'(dims);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic int draw_sample();
      int pick;

      pick = $urandom_range(0, 9);
      if (pick < 5) return $urandom_range(0, 65535);
      if (pick < 8) return int'($urandom_range(0, 512)) - 256;
      return (pick == 8) ? 32767 : -32768;
   endfunction

   // Mostly a handful of low clusters, so that members pile up and means mean something.
   function automatic int pick_cluster(input int eff_clusters);
      int hot;

      hot = (eff_clusters < 4) ? eff_clusters : 4;
      if ($urandom_range(0, 3) != 0) return $urandom_range(0, hot - 1);
      return $urandom_range(0, eff_clusters - 1);
   endfunction

   // One setting of the registers, then vectors, reads, broken vectors and noise.
   task automatic run_random_phase(input int clusters, input int dims, input int quota,
                                   input bit with_clear);
      int                sent;
      int                clear_at;
      int                pick;
      int                hot_c;
      int                eff_clusters;
      int                eff_dims;
      int                len;
      logic [MODE_W-1:0] noise_mode;

      write_regs(clusters, dims);
      eff_clusters = (clusters > MAX_CLUSTERS_DEF) ? MAX_CLUSTERS_DEF : clusters;
      eff_dims     = (dims > MAX_DIM_DEF) ? MAX_DIM_DEF : dims;
      clear_at     = with_clear ? $urandom_range(quota / 4, 3 * quota / 4) : -1;
      sent         = 0;
      while (sent < quota) begin
         pick = $urandom_range(0, 99);
         if (clear_at >= 0 && sent >= clear_at) begin
            send_request(MODE_CLEAR, $urandom_range(0, 511), $urandom_range(0, 127),
                         draw_sample(), $urandom_range(0, 1));
            clear_at = -1;
            sent++;
         end else if (pick < 55) begin
            // Well-formed vector, with reads slipped in between its elements.
            hot_c = pick_cluster(eff_clusters);
            for (int k = 0; k < eff_dims; k++) begin
               send_request(MODE_ACCUMULATE, hot_c, k, draw_sample(), k == eff_dims - 1);
               sent++;
               if ($urandom_range(0, 5) == 0) begin
                  send_request(MODE_READ, pick_cluster(eff_clusters),
                               $urandom_range(0, eff_dims - 1), draw_sample(),
                               $urandom_range(0, 1));
                  sent++;
               end
            end
         end else if (pick < 78) begin
            send_request(MODE_READ, pick_cluster(eff_clusters),
                         $urandom_range(0, eff_dims - 1), draw_sample(), $urandom_range(0, 1));
            sent++;
         end else if (pick < 80) begin
            drain_means();
         end else if (pick < 88) begin
            // Broken vector: short, dimensions in any order, member flag at random.
            hot_c = pick_cluster(eff_clusters);
            len   = $urandom_range(1, eff_dims);
            for (int k = 0; k < len; k++) begin
               send_request(MODE_ACCUMULATE, hot_c, $urandom_range(0, 127), draw_sample(),
                            $urandom_range(0, 3) == 0);
               sent++;
            end
         end else begin
            noise_mode = MODE_W'($urandom_range(0, 3));
            if (noise_mode == MODE_CLEAR) noise_mode = MODE_UNUSED;
            send_request(noise_mode, $urandom_range(0, 511), $urandom_range(0, 127),
                         draw_sample(), $urandom_range(0, 1));
            sent++;
         end
      end
   endtask

   initial begin
      req_chan.valid      <= 1'b0;
      req_chan.mode       <= MODE_ACCUMULATE;
      req_chan.cluster    <= '0;
      req_chan.dim_index  <= '0;
      req_chan.sample     <= '0;
      req_chan.vector_end <= 1'b0;
      csr_we              <= 1'b0;
      csr_index           <= CSR_NUM_CLUSTERS;
      csr_wdata           <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Empty store, then the extremes of cluster, dimension and sample.
      send_request(MODE_READ, 0, 0, 0, 1'b0);
      send_request(MODE_ACCUMULATE, 255, 127, 32767, 1'b1);
      send_request(MODE_ACCUMULATE, 255, 0, -32768, 1'b1);
      send_request(MODE_READ, 255, 127, 0, 1'b0);
      send_request(MODE_READ, 255, 0, 0, 1'b0);
      send_request(MODE_READ, 255, 64, 0, 1'b1);

      // A negative mean truncates toward zero.
      send_request(MODE_ACCUMULATE, 2, 1, -3, 1'b1);
      send_request(MODE_ACCUMULATE, 2, 1, 0, 1'b1);
      send_request(MODE_READ, 2, 1, 0, 1'b0);

      // Negative cluster ids are skipped and read as empty.
      send_request(MODE_ACCUMULATE, -1, 0, 100, 1'b1);
      send_request(MODE_ACCUMULATE, -256, 0, 100, 1'b1);
      send_request(MODE_READ, -1, 0, 0, 1'b0);
      send_request(MODE_READ, -256, 0, 0, 1'b0);

      // The unused mode must leave the store alone.
      send_request(MODE_UNUSED, 2, 1, 1234, 1'b1);
      send_request(MODE_READ, 2, 1, 0, 1'b0);

      // Cluster and dimension beyond the registers; the member still counts.
      write_regs(3, 2);
      send_request(MODE_ACCUMULATE, 3, 0, 77, 1'b1);
      send_request(MODE_READ, 3, 0, 0, 1'b0);
      send_request(MODE_ACCUMULATE, 1, 2, 500, 1'b1);
      send_request(MODE_READ, 1, 2, 0, 1'b0);
      send_request(MODE_READ, 1, 1, 0, 1'b0);
      send_request(MODE_CLEAR, 0, 0, 0, 1'b0);
      send_request(MODE_READ, 1, 1, 0, 1'b0);

      // Zero registers make every id invalid.
      write_regs(0, 0);
      send_request(MODE_ACCUMULATE, 0, 0, 5, 1'b1);
      send_request(MODE_READ, 0, 0, 0, 1'b0);

      // Register values beyond the store sizes are clamped.
      write_regs(511, 255);
      send_request(MODE_ACCUMULATE, 255, 127, -7, 1'b1);
      send_request(MODE_READ, 255, 127, 0, 1'b0);

      run_random_phase(5, 6, 300, 1'b1);
      run_random_phase(1, 128, 260, 1'b0);
      run_random_phase(511, 3, 300, 1'b1);
      run_random_phase(256, 1, 300, 1'b0);

      // A single member over a large sum pushes the mean past the Q8.8 range on both signs.
      write_regs(256, 255);
      send_request(MODE_CLEAR, 0, 0, 0, 1'b0);
      bulk_mode = 1'b1;
      for (int k = 0; k < 3; k++) begin
         send_request(MODE_ACCUMULATE, SAT_CLUSTER, 0, 32767, 1'b0);
         send_request(MODE_ACCUMULATE, SAT_CLUSTER, 1, -32768, k == 2);
      end
      bulk_mode = 1'b0;
      send_request(MODE_READ, SAT_CLUSTER, 0, 0, 1'b0);
      send_request(MODE_READ, SAT_CLUSTER, 1, 0, 1'b0);
      send_request(MODE_READ, SAT_CLUSTER + 1, 0, 0, 1'b0);

      drain_means();
      repeat (40) @(posedge clock);
      if (mismatch_total == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
